FILE: hdl/fccd_pkg.sv
package fccd_pkg;

    localparam logic [3:0][7:0] SYNC_WORD = {8'h74, 8'h61, 8'h70, 8'h73};
    localparam logic [1:0]      SYNC_LAST = 2'd3;
    localparam logic [7:0]      CC_STATUS = 8'hB0;
    localparam logic [7:0]      EDGE_HIGH = 8'd127;
    localparam logic [5:0]      MAX_EVENTS = 6'd32;

    localparam int CFG_DATA_W = 7;

    typedef enum logic {
        CFG_MIDI_CHANNEL = 1'b0,
        CFG_DEADBAND     = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_TEST,
        B_END
    } t_back_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_item;

    typedef struct packed {
        logic [7:0] status;
        logic [5:0] number;
        logic [7:0] value;
        logic       last;
    } t_cc_event;

endpackage

FILE: hdl/fccd_front.sv
module fccd_front #(
    parameter int FRAME_ENTRIES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output fccd_pkg::t_frame_item o_push_item
);

    localparam int IDX_W = (FRAME_ENTRIES > 1) ? $clog2(FRAME_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_ENTRIES - 1);

    logic             r_synced;
    logic             n_synced;
    logic [1:0]       r_sync_pos;
    logic [1:0]       n_sync_pos;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] n_pos;
    logic             w_accept;
    logic             w_frame_end;

    assign o_ready      = !r_synced || i_push_ready;
    assign w_accept     = i_valid && o_ready;
    assign w_frame_end  = (r_pos == LAST_IDX);
    assign o_push_valid = w_accept && r_synced;
    assign o_push_item  = '{data: i_data, last: w_frame_end};

    always_comb begin
        n_synced   = r_synced;
        n_sync_pos = r_sync_pos;
        n_pos      = r_pos;
        if (w_accept) begin
            if (!r_synced) begin
                if (i_data == fccd_pkg::SYNC_WORD[r_sync_pos]) begin
                    if (r_sync_pos == fccd_pkg::SYNC_LAST) begin
                        n_synced   = 1'b1;
                        n_sync_pos = 2'd0;
                    end else begin
                        n_sync_pos = r_sync_pos + 2'd1;
                    end
                end else begin
                    n_sync_pos = 2'd0;
                end
            end else begin
                n_pos = w_frame_end ? '0 : r_pos + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced   <= 1'b0;
            r_sync_pos <= 2'd0;
            r_pos      <= '0;
        end else begin
            r_synced   <= n_synced;
            r_sync_pos <= n_sync_pos;
            r_pos      <= n_pos;
        end
    end

endmodule

FILE: hdl/fccd_queue.sv
module fccd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push_valid,
    output logic                  o_push_ready,
    input  fccd_pkg::t_frame_item i_push_item,
    output logic                  o_pop_valid,
    input  logic                  i_pop_ready,
    output fccd_pkg::t_frame_item o_pop_item
);

    fccd_pkg::t_frame_item r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_item   = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: hdl/fccd_back.sv
module fccd_back #(
    parameter int FRAME_ENTRIES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [3:0]            i_midi_channel,
    input  logic [6:0]            i_deadband,
    input  logic                  i_pop_valid,
    output logic                  o_pop_ready,
    input  fccd_pkg::t_frame_item i_pop_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fccd_pkg::t_cc_event   o_event
);

    localparam int IDX_W = (FRAME_ENTRIES > 1) ? $clog2(FRAME_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_ENTRIES - 1);

    logic [7:0] r_fs_mem [FRAME_ENTRIES];
    logic [7:0] r_sv_mem [FRAME_ENTRIES];
    logic [FRAME_ENTRIES-1:0] r_sv_vld;
    logic [7:0] r_fs_rd;
    logic [7:0] r_sv_rd;

    fccd_pkg::t_back_state r_state;
    fccd_pkg::t_back_state n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] r_wr_idx;
    logic [IDX_W-1:0] n_wr_idx;
    logic [5:0]       r_count;
    logic [5:0]       n_count;
    logic             r_pend_vld;
    logic             n_pend_vld;
    logic [IDX_W-1:0] r_pend_num;
    logic [IDX_W-1:0] n_pend_num;
    logic [7:0]       r_pend_val;
    logic [7:0]       n_pend_val;
    logic             r_out_vld;
    fccd_pkg::t_cc_event r_out_evt;

    logic       w_fs_we;
    logic       w_sv_we;
    logic       w_rd_en;
    logic       w_out_load;
    logic       w_out_last;
    logic       w_out_free;
    logic [7:0] w_diff;
    logic signed [8:0] w_diff_s;
    logic signed [8:0] w_lim_s;
    logic       w_fire;

    assign w_diff     = r_fs_rd - r_sv_rd;
    assign w_diff_s   = $signed({w_diff[7], w_diff});
    assign w_lim_s    = $signed({2'b00, i_deadband});
    assign w_fire     = (w_diff_s > w_lim_s) || (w_diff_s < -w_lim_s)
                        || ((w_diff != 8'd0)
                            && ((r_fs_rd == 8'd0) || (r_fs_rd == fccd_pkg::EDGE_HIGH)));
    assign w_out_free = !r_out_vld || i_ready;
    assign w_rd_en    = (r_state == fccd_pkg::B_READ);
    assign o_valid    = r_out_vld;
    assign o_event    = r_out_evt;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_wr_idx    = r_wr_idx;
        n_count     = r_count;
        n_pend_vld  = r_pend_vld;
        n_pend_num  = r_pend_num;
        n_pend_val  = r_pend_val;
        o_pop_ready = 1'b0;
        w_fs_we     = 1'b0;
        w_sv_we     = 1'b0;
        w_out_load  = 1'b0;
        w_out_last  = 1'b0;
        unique case (r_state)
            fccd_pkg::B_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    w_fs_we = 1'b1;
                    if (i_pop_item.last) begin
                        n_wr_idx   = '0;
                        n_idx      = '0;
                        n_count    = 6'd0;
                        n_pend_vld = 1'b0;
                        n_state    = fccd_pkg::B_READ;
                    end else begin
                        n_wr_idx = r_wr_idx + IDX_W'(1);
                    end
                end
            end
            fccd_pkg::B_READ: begin
                n_state = fccd_pkg::B_TEST;
            end
            fccd_pkg::B_TEST: begin
                if (w_fire && (r_count == fccd_pkg::MAX_EVENTS)) begin
                    n_state = fccd_pkg::B_END;
                end else if (w_fire && r_pend_vld && !w_out_free) begin
                    n_state = fccd_pkg::B_TEST;
                end else begin
                    if (w_fire) begin
                        w_out_load = r_pend_vld;
                        n_pend_vld = 1'b1;
                        n_pend_num = r_idx;
                        n_pend_val = r_fs_rd;
                        w_sv_we    = 1'b1;
                        n_count    = r_count + 6'd1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = fccd_pkg::B_END;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = fccd_pkg::B_READ;
                    end
                end
            end
            fccd_pkg::B_END: begin
                if (!r_pend_vld) begin
                    n_state = fccd_pkg::B_IDLE;
                end else if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_last = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = fccd_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = fccd_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_fs_we) begin
            r_fs_mem[r_wr_idx] <= i_pop_item.data;
        end
        if (w_rd_en) begin
            r_fs_rd <= r_fs_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sv_we) begin
            r_sv_mem[r_idx] <= r_fs_rd;
        end
        if (w_rd_en) begin
            r_sv_rd <= r_sv_vld[r_idx] ? r_sv_mem[r_idx] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv_vld <= '0;
        end else if (w_sv_we) begin
            r_sv_vld[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_evt.status <= fccd_pkg::CC_STATUS | {4'h0, i_midi_channel};
            r_out_evt.number <= 6'(r_pend_num);
            r_out_evt.value  <= r_pend_val;
            r_out_evt.last   <= w_out_last;
        end
        r_pend_num <= n_pend_num;
        r_pend_val <= n_pend_val;
        r_idx      <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fccd_pkg::B_IDLE;
            r_wr_idx   <= '0;
            r_count    <= 6'd0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr_idx   <= n_wr_idx;
            r_count    <= n_count;
            r_pend_vld <= n_pend_vld;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/framed_control_change_detector.sv
// Channel      Direction  Beat contents
// s (i_s_*)    in         tdata: rx_byte
// m (o_m_*)    out        tdata: status_byte, control_number, control_value; tlast: last
// cfg (i_cfg_*) in        index 0 midi_channel, index 1 deadband
//
// A byte is taken while unsynced or the queue has room; frame bytes pass a two-beat queue to the scan unit.
// Ending a frame starts a scan that reads each entry from memory and then compares it,
// waiting whenever the output is stalled; meanwhile the queue takes up to
// two more bytes, and then the input stalls until the scan ends.
// Reset is synchronous and clears the sent-value store at once through per-entry valid bits.
// An event waits in a one-beat hold stage until the next one is found, so tlast is known.
module framed_control_change_detector #(
    parameter int FRAME_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] status_byte, [13:8] control_number,
                                     // [21:14] control_value, [23:22] zero
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [fccd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [3:0] r_midi_channel;
    logic [6:0] r_deadband;

    logic                  w_push_valid;
    logic                  w_push_ready;
    fccd_pkg::t_frame_item w_push_item;
    logic                  w_pop_valid;
    logic                  w_pop_ready;
    fccd_pkg::t_frame_item w_pop_item;
    fccd_pkg::t_cc_event   w_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midi_channel <= 4'd0;
            r_deadband     <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (fccd_pkg::t_cfg_index'(i_cfg_index))
                fccd_pkg::CFG_MIDI_CHANNEL: r_midi_channel <= i_cfg_wdata[3:0];
                fccd_pkg::CFG_DEADBAND:     r_deadband     <= i_cfg_wdata[6:0];
                default:                    r_deadband     <= r_deadband;
            endcase
        end
    end

    fccd_front #(
        .FRAME_ENTRIES(FRAME_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_data       (i_s_tdata),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_item  (w_push_item)
    );

    fccd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_item  (w_push_item),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_item   (w_pop_item)
    );

    fccd_back #(
        .FRAME_ENTRIES(FRAME_ENTRIES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_midi_channel (r_midi_channel),
        .i_deadband     (r_deadband),
        .i_pop_valid    (w_pop_valid),
        .o_pop_ready    (w_pop_ready),
        .i_pop_item     (w_pop_item),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_event        (w_event)
    );

    assign o_m_tdata = {2'b00, w_event.value, w_event.number, w_event.status};
    assign o_m_tlast = w_event.last;

    a_push_has_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid |-> w_push_ready)
        else $error("frame byte pushed into a full queue");

    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:4] == 4'hB) && (o_m_tdata[23:22] == 2'b00))
        else $error("event beat without control-change status");

    a_no_pop_in_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_valid && w_pop_ready && w_pop_item.last) |=> !w_pop_ready)
        else $error("queue drained while a frame scan should run");

endmodule
